[design/cpu_alu_register_file_macros.svh]
// Assertion macros shared by the ALU and register file design.
// Depends on a clock named clk and an active-low reset named arst_n in the user's scope.
`ifndef CPU_ALU_REGISTER_FILE_MACROS_SVH
`define CPU_ALU_REGISTER_FILE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CALURF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CALURF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/calurf_pkg.sv]
// Shared types and operation codes for the 8-bit ALU with register file.
// No dependencies; used by calurf_exec and cpu_alu_register_file.
`timescale 1ns / 1ps

package calurf_pkg;

	// Operation codes; codes 18 to 31 are no-operations.
	localparam logic [4:0] FN_ADD   = 5'd0;
	localparam logic [4:0] FN_SUB   = 5'd1;
	localparam logic [4:0] FN_CP    = 5'd2;
	localparam logic [4:0] FN_AND   = 5'd3;
	localparam logic [4:0] FN_OR    = 5'd4;
	localparam logic [4:0] FN_XOR   = 5'd5;
	localparam logic [4:0] FN_INC8  = 5'd6;
	localparam logic [4:0] FN_DEC8  = 5'd7;
	localparam logic [4:0] FN_INC16 = 5'd8;
	localparam logic [4:0] FN_DEC16 = 5'd9;
	localparam logic [4:0] FN_ADDHL = 5'd10;
	localparam logic [4:0] FN_RL    = 5'd11;
	localparam logic [4:0] FN_SLA   = 5'd12;
	localparam logic [4:0] FN_SRL   = 5'd13;
	localparam logic [4:0] FN_SWAP  = 5'd14;
	localparam logic [4:0] FN_BIT   = 5'd15;
	localparam logic [4:0] FN_RES   = 5'd16;
	localparam logic [4:0] FN_CPL   = 5'd17;

	// 8-bit operand selectors.
	localparam logic [2:0] SEL_B   = 3'd0;
	localparam logic [2:0] SEL_C   = 3'd1;
	localparam logic [2:0] SEL_D   = 3'd2;
	localparam logic [2:0] SEL_E   = 3'd3;
	localparam logic [2:0] SEL_H   = 3'd4;
	localparam logic [2:0] SEL_L   = 3'd5;
	localparam logic [2:0] SEL_MEM = 3'd6;
	localparam logic [2:0] SEL_A   = 3'd7;

	// 16-bit pair selectors.
	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam logic [1:0] PAIR_SP = 2'd3;

	// Instruction clock counts.
	localparam logic [4:0] CYC_4  = 5'd4;
	localparam logic [4:0] CYC_8  = 5'd8;
	localparam logic [4:0] CYC_12 = 5'd12;
	localparam logic [4:0] CYC_16 = 5'd16;

	typedef struct packed {
		logic [4:0] func;
		logic [2:0] reg_sel;
		logic [1:0] pair_sel;
		logic [2:0] bit_index;
		logic       use_immediate;
		logic [7:0] operand_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]  result_value;
		logic        flag_zero;
		logic        flag_subtract;
		logic        flag_half_carry;
		logic        flag_carry;
		logic        mem_write;
		logic [15:0] mem_address;
		logic [4:0]  cycles;
	} result_t;

	// Architectural state: flags are Z, N, H, C from bit 3 down.
	typedef struct packed {
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [7:0]  e;
		logic [7:0]  h;
		logic [7:0]  l;
		logic [7:0]  a;
		logic [15:0] sp;
		logic [3:0]  flags;
	} state_t;

endpackage

[design/calurf_exec.sv]
// Execute logic: one operation on the current register state, giving the result
// and the next state. Purely combinational; depends on calurf_pkg.
`timescale 1ns / 1ps

module calurf_exec (
	input  calurf_pkg::item_t   item,
	input  calurf_pkg::state_t  cur,
	output calurf_pkg::result_t res,
	output calurf_pkg::state_t  nxt
);

	logic [7:0]  opa;
	logic [7:0]  v;
	logic [7:0]  src;
	logic [15:0] hl;
	logic [15:0] pv;
	logic        is_mem;
	logic [4:0]  alu_cyc;
	logic [4:0]  shf_cyc;
	logic [8:0]  add9;
	logic [4:0]  add_nib;
	logic [8:0]  sub9;
	logic [16:0] add17;
	logic [12:0] add_hl12;

	assign opa    = cur.a;
	assign hl     = {cur.h, cur.l};
	assign is_mem = (item.reg_sel == calurf_pkg::SEL_MEM);

	always_comb begin
		case (item.reg_sel)
			calurf_pkg::SEL_B:   v = cur.b;
			calurf_pkg::SEL_C:   v = cur.c;
			calurf_pkg::SEL_D:   v = cur.d;
			calurf_pkg::SEL_E:   v = cur.e;
			calurf_pkg::SEL_H:   v = cur.h;
			calurf_pkg::SEL_L:   v = cur.l;
			calurf_pkg::SEL_MEM: v = item.operand_byte;
			default:             v = cur.a;
		endcase
	end

	always_comb begin
		case (item.pair_sel)
			calurf_pkg::PAIR_BC: pv = {cur.b, cur.c};
			calurf_pkg::PAIR_DE: pv = {cur.d, cur.e};
			calurf_pkg::PAIR_HL: pv = {cur.h, cur.l};
			default:             pv = cur.sp;
		endcase
	end

	assign src      = item.use_immediate ? item.operand_byte : v;
	assign alu_cyc  = (item.use_immediate || is_mem) ? calurf_pkg::CYC_8 : calurf_pkg::CYC_4;
	assign shf_cyc  = is_mem ? calurf_pkg::CYC_16 : calurf_pkg::CYC_8;
	assign add9     = {1'b0, opa} + {1'b0, src};
	assign add_nib  = {1'b0, opa[3:0]} + {1'b0, src[3:0]};
	assign sub9     = {1'b0, opa} - {1'b0, src};
	assign add17    = {1'b0, pv} + {1'b0, hl};
	assign add_hl12 = {1'b0, pv[11:0]} + {1'b0, hl[11:0]};

	always_comb begin
		logic [7:0]  r;
		logic        fz;
		logic        fn;
		logic        fh;
		logic        fc;
		logic [4:0]  cyc;
		logic        wr8;
		logic        wr16;
		logic [1:0]  pair16;
		logic [15:0] val16;

		nxt    = cur;
		r      = opa;
		fz     = cur.flags[3];
		fn     = cur.flags[2];
		fh     = cur.flags[1];
		fc     = cur.flags[0];
		cyc    = calurf_pkg::CYC_4;
		wr8    = 1'b0;
		wr16   = 1'b0;
		pair16 = item.pair_sel;
		val16  = pv;

		case (item.func)
			calurf_pkg::FN_ADD: begin
				r     = add9[7:0];
				fz    = (r == 8'h00);
				fn    = 1'b0;
				fh    = add_nib[4];
				fc    = add9[8];
				nxt.a = r;
				cyc   = alu_cyc;
			end
			calurf_pkg::FN_SUB, calurf_pkg::FN_CP: begin
				r  = sub9[7:0];
				fz = (r == 8'h00);
				fn = 1'b1;
				fh = (opa[3:0] < src[3:0]);
				fc = sub9[8];
				if (item.func == calurf_pkg::FN_SUB) begin
					nxt.a = r;
				end else begin
					r = opa;
				end
				cyc = alu_cyc;
			end
			calurf_pkg::FN_AND, calurf_pkg::FN_OR, calurf_pkg::FN_XOR: begin
				if (item.func == calurf_pkg::FN_AND) begin
					r = opa & src;
				end else if (item.func == calurf_pkg::FN_OR) begin
					r = opa | src;
				end else begin
					r = opa ^ src;
				end
				fz    = (r == 8'h00);
				fn    = 1'b0;
				fh    = (item.func == calurf_pkg::FN_AND);
				fc    = 1'b0;
				nxt.a = r;
				cyc   = alu_cyc;
			end
			calurf_pkg::FN_INC8: begin
				fh  = (v[3:0] == 4'hf);
				r   = v + 8'd1;
				fz  = (r == 8'h00);
				fn  = 1'b0;
				wr8 = 1'b1;
				cyc = is_mem ? calurf_pkg::CYC_12 : calurf_pkg::CYC_4;
			end
			calurf_pkg::FN_DEC8: begin
				fh  = (v[3:0] == 4'h0);
				r   = v - 8'd1;
				fz  = (r == 8'h00);
				fn  = 1'b1;
				wr8 = 1'b1;
				cyc = is_mem ? calurf_pkg::CYC_12 : calurf_pkg::CYC_4;
			end
			calurf_pkg::FN_INC16, calurf_pkg::FN_DEC16: begin
				val16 = (item.func == calurf_pkg::FN_INC16) ? pv + 16'd1 : pv - 16'd1;
				wr16  = 1'b1;
				r     = 8'h00;
				cyc   = calurf_pkg::CYC_8;
			end
			calurf_pkg::FN_ADDHL: begin
				fn     = 1'b0;
				fh     = add_hl12[12];
				fc     = add17[16];
				val16  = add17[15:0];
				pair16 = calurf_pkg::PAIR_HL;
				wr16   = 1'b1;
				r      = 8'h00;
				cyc    = calurf_pkg::CYC_8;
			end
			calurf_pkg::FN_RL, calurf_pkg::FN_SLA, calurf_pkg::FN_SRL,
			calurf_pkg::FN_SWAP: begin
				if (item.func == calurf_pkg::FN_RL) begin
					r  = {v[6:0], cur.flags[0]};
					fc = v[7];
				end else if (item.func == calurf_pkg::FN_SLA) begin
					r  = {v[6:0], 1'b0};
					fc = v[7];
				end else if (item.func == calurf_pkg::FN_SRL) begin
					r  = {1'b0, v[7:1]};
					fc = v[0];
				end else begin
					r  = {v[3:0], v[7:4]};
					fc = 1'b0;
				end
				fz  = (r == 8'h00);
				fn  = 1'b0;
				fh  = 1'b0;
				wr8 = 1'b1;
				cyc = shf_cyc;
			end
			calurf_pkg::FN_BIT: begin
				fz  = ~v[item.bit_index];
				fn  = 1'b0;
				fh  = 1'b1;
				cyc = shf_cyc;
			end
			calurf_pkg::FN_RES: begin
				r   = v & 8'hfe;
				wr8 = 1'b1;
				cyc = shf_cyc;
			end
			calurf_pkg::FN_CPL: begin
				r     = ~opa;
				fn    = 1'b1;
				fh    = 1'b1;
				nxt.a = r;
			end
			default: begin
			end
		endcase

		// A memory destination becomes a write-back request instead of a register write.
		if (wr8) begin
			case (item.reg_sel)
				calurf_pkg::SEL_B:   nxt.b = r;
				calurf_pkg::SEL_C:   nxt.c = r;
				calurf_pkg::SEL_D:   nxt.d = r;
				calurf_pkg::SEL_E:   nxt.e = r;
				calurf_pkg::SEL_H:   nxt.h = r;
				calurf_pkg::SEL_L:   nxt.l = r;
				calurf_pkg::SEL_A:   nxt.a = r;
				default: begin
				end
			endcase
		end

		if (wr16) begin
			case (pair16)
				calurf_pkg::PAIR_BC: {nxt.b, nxt.c} = val16;
				calurf_pkg::PAIR_DE: {nxt.d, nxt.e} = val16;
				calurf_pkg::PAIR_HL: {nxt.h, nxt.l} = val16;
				default:             nxt.sp = val16;
			endcase
		end

		nxt.flags           = {fz, fn, fh, fc};
		res.result_value    = r;
		res.flag_zero       = fz;
		res.flag_subtract   = fn;
		res.flag_half_carry = fh;
		res.flag_carry      = fc;
		res.mem_write       = wr8 && is_mem;
		res.mem_address     = hl;
		res.cycles          = cyc;
	end

endmodule

[design/cpu_alu_register_file.sv]
// An accepted item waits in the input register. Throughput: one item per cycle unless
// the output stalls; the input register executes against the register file and moves
// to the output register in the same cycle, so each item sees the state left by the
// one before. Reset clears all registers, SP and flags to zero.
// Depends on calurf_pkg, calurf_exec and cpu_alu_register_file_macros.svh.
`timescale 1ns / 1ps
`include "cpu_alu_register_file_macros.svh"

module cpu_alu_register_file (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// func[4:0], reg_sel[7:5], pair_sel[9:8], bit_index[12:10], operand_byte[20:13], zeros
	input  logic [23:0] s_tdata,
	// use_immediate[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_value[7:0], flag_zero[8], flag_subtract[9], flag_half_carry[10],
	// flag_carry[11], mem_write[12], mem_address[28:13], cycles[33:29], zeros
	output logic [39:0] m_tdata
);

	calurf_pkg::item_t   item_in;
	calurf_pkg::item_t   item_s1;
	logic                valid_s1;
	calurf_pkg::state_t  state_q;
	calurf_pkg::state_t  state_nxt;
	calurf_pkg::result_t exec_res;
	calurf_pkg::result_t out_q;
	logic                out_valid_q;
	logic                advance;
	logic                accept;

	assign item_in.func          = s_tdata[4:0];
	assign item_in.reg_sel       = s_tdata[7:5];
	assign item_in.pair_sel      = s_tdata[9:8];
	assign item_in.bit_index     = s_tdata[12:10];
	assign item_in.operand_byte  = s_tdata[20:13];
	assign item_in.use_immediate = s_tuser[0];

	// The held item executes once the output register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	calurf_exec u_exec (
		.item (item_s1),
		.cur  (state_q),
		.res  (exec_res),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			out_q <= exec_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.cycles, out_q.mem_address, out_q.mem_write,
		out_q.flag_carry, out_q.flag_half_carry, out_q.flag_subtract, out_q.flag_zero,
		out_q.result_value};

	`CALURF_ASSERT_NEXT(a_state_only_on_advance, !advance, $stable(state_q),
		"architectural state changed without an executing item")
	`CALURF_ASSERT_NEXT(a_result_follows_advance, advance, out_valid_q,
		"executed item did not reach the output register")
	`CALURF_ASSERT_NOW(a_mem_write_only_for_memory, advance && exec_res.mem_write,
		item_s1.reg_sel == calurf_pkg::SEL_MEM,
		"memory write-back raised for a register operand")
	`CALURF_ASSERT_NOW(a_sp_only_by_pair_op, advance && (state_nxt.sp != state_q.sp),
		(item_s1.pair_sel == calurf_pkg::PAIR_SP) &&
		(item_s1.func == calurf_pkg::FN_INC16 || item_s1.func == calurf_pkg::FN_DEC16),
		"stack pointer changed by an operation that does not address it")
	`CALURF_ASSERT_NOW(a_cycle_count_legal, out_valid_q,
		out_q.cycles == calurf_pkg::CYC_4 || out_q.cycles == calurf_pkg::CYC_8 ||
		out_q.cycles == calurf_pkg::CYC_12 || out_q.cycles == calurf_pkg::CYC_16,
		"cycle count outside the legal set")

endmodule
